### design/dijt_pkg.sv
// Package: constants, codes and types shared by the join table design.
`timescale 1ns / 1ps
package dijt_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 65536;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);

    // Field widths
    localparam int OPCODE_W  = 2;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 32;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int MODE_W  = 2;

    // Register index of the width mode register
    localparam logic [0:0] REG_WIDTH_MODE = 1'b0;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_BUILD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PROBE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEG_KEY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_KEY_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NEG_PAYLOAD = 3'd4;

    // Width mode codes; any other code keeps all four bytes
    localparam logic [MODE_W-1:0] WM_BYTE   = 2'd0;
    localparam logic [MODE_W-1:0] WM_HALF   = 2'd1;
    localparam logic [MODE_W-1:0] WM_RESET  = 2'd2;

    // One table entry: presence mark and stored word
    typedef struct packed {
        logic                 present;
        logic [PAYLOAD_W-1:0] word;
    } entry_t;

    // Write request into the table memory
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_LOOKUP
    } state_t;

endpackage

### design/dijt_req_if.sv
// Interface: request channel carrying opcode, key and payload.
`timescale 1ns / 1ps
interface dijt_req_if;
    import dijt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output opcode, output key, output payload, input ready);
    modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

### design/dijt_rsp_if.sv
// Interface: response channel carrying status, hit flag, payload and match count.
`timescale 1ns / 1ps
interface dijt_rsp_if;
    import dijt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 hit;
    logic [PAYLOAD_W-1:0] hit_payload;
    logic [COUNT_W-1:0]   match_count;

    modport source (output valid, output status, output hit, output hit_payload,
                     output match_count, input ready);
    modport sink   (input valid, input status, input hit, input hit_payload,
                     input match_count, output ready);
endinterface

### design/dijt_store.sv
// Table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module dijt_store (
    input  logic                        clk,
    input  dijt_pkg::mem_wr_t           wr,
    input  logic                        rd_en,
    input  logic [dijt_pkg::SLOT_W-1:0] rd_addr,
    output dijt_pkg::entry_t            rd_data
);
    import dijt_pkg::*;

    entry_t mem [TABLE_SLOTS];
    entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/direct_index_join_table.sv
// Top level: direct-addressed join table with request/response channels and APB port.
`timescale 1ns / 1ps
// Each slot of the table holds a presence mark and a 32-bit word in one on-chip memory.
// A build or probe transaction reads its slot in the accept cycle; the registered read data is
// checked, answered and written back in S_LOOKUP, which holds while the response register
// cannot take the result. No new request is taken until the current one is answered. After
// reset and after every clear, the block sweeps all TABLE_SLOTS entries to drop the presence
// marks and takes no request meanwhile; APB writes are taken at all times. The clear response
// itself is issued as the sweep begins, without waiting for the sweep to end.
module direct_index_join_table (
    input  logic                         clk,
    input  logic                         rst_n,
    dijt_req_if.sink                     req,
    dijt_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dijt_pkg::PADDR_W-1:0] paddr,
    input  logic [dijt_pkg::PDATA_W-1:0] pwdata,
    output logic [dijt_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import dijt_pkg::*;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic [MODE_W-1:0]    width_mode_reg;
    logic [COUNT_W-1:0]   hit_count_reg, hit_count_next;

    logic [OPCODE_W-1:0]  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 hit_reg, hit_next;
    logic [PAYLOAD_W-1:0] hit_payload_reg, hit_payload_next;
    logic [COUNT_W-1:0]   match_count_reg, match_count_next;

    mem_wr_t              mem_wr;
    logic                 rd_en;
    entry_t               rd_data;

    logic                 req_fire;
    logic                 out_free;
    logic                 key_neg;
    logic                 key_in_range;
    logic                 slot_hit;
    logic [PAYLOAD_W-1:0] cut_word;
    logic                 cfg_write;

    // Table memory
    dijt_store u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (req.key[SLOT_W-1:0]),
        .rd_data (rd_data)
    );

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_WIDTH_MODE);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_WIDTH_MODE)
                       ? {{(PDATA_W-MODE_W){1'b0}}, width_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_mode_reg <= WM_RESET;
        end
        else if (cfg_write)
        begin
            width_mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    // Request handshake
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rd_en     = req_fire;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg      <= req.opcode;
            key_reg     <= req.key;
            payload_reg <= req.payload;
        end
    end

    // Key checks and payload cut
    assign key_neg      = key_reg[KEY_W-1];
    assign key_in_range = !key_neg && (key_reg < KEY_W'(TABLE_SLOTS));
    assign slot_hit     = key_in_range && rd_data.present;
    assign out_free     = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (width_mode_reg)
            WM_BYTE: cut_word = {{(PAYLOAD_W-8){1'b0}}, payload_reg[7:0]};
            WM_HALF: cut_word = {{(PAYLOAD_W-16){1'b0}}, payload_reg[15:0]};
            default: cut_word = payload_reg;
        endcase
    end

    // Sequencer: sweep, accept, check and write back
    always_comb
    begin
        state_next       = state_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        hit_count_next   = hit_count_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        status_next      = status_reg;
        hit_next         = hit_reg;
        hit_payload_next = hit_payload_reg;
        match_count_next = match_count_reg;
        mem_wr.en        = 1'b0;
        mem_wr.addr      = key_reg[SLOT_W-1:0];
        mem_wr.data.present = 1'b1;
        mem_wr.data.word    = cut_word;

        case (state_reg)
            S_SWEEP:
            begin
                mem_wr.en           = 1'b1;
                mem_wr.addr         = sweep_cnt_reg;
                mem_wr.data.present = 1'b0;
                mem_wr.data.word    = '0;
                sweep_cnt_next      = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    sweep_cnt_next = '0;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // Hold until the response register can take the result
                if (out_free)
                begin
                    status_next      = ST_OK;
                    hit_next         = 1'b0;
                    hit_payload_next = '0;
                    state_next       = S_IDLE;
                    if (op_reg == OP_BUILD)
                    begin
                        if (key_neg)
                        begin
                            status_next = ST_NEG_KEY;
                        end
                        else if (!key_in_range)
                        begin
                            status_next = ST_KEY_RANGE;
                        end
                        else if (rd_data.present)
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        else if (payload_reg[PAYLOAD_W-1])
                        begin
                            status_next = ST_NEG_PAYLOAD;
                        end
                        else
                        begin
                            mem_wr.en = 1'b1;
                        end
                    end
                    else if (op_reg == OP_PROBE)
                    begin
                        if (slot_hit)
                        begin
                            hit_next         = 1'b1;
                            hit_payload_next = rd_data.word;
                            if (hit_count_reg != '1)
                            begin
                                hit_count_next = hit_count_reg + 1'b1;
                            end
                        end
                    end
                    else if (op_reg == OP_CLEAR)
                    begin
                        hit_count_next = '0;
                        state_next     = S_SWEEP;
                    end
                    match_count_next = hit_count_next;
                    out_valid_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_SWEEP;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_cnt_reg <= '0;
            hit_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            hit_count_reg <= hit_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        hit_reg         <= hit_next;
        hit_payload_reg <= hit_payload_next;
        match_count_reg <= match_count_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.hit_payload = hit_payload_reg;
    assign rsp.match_count = match_count_reg;

endmodule

### tb/direct_index_join_table_tb.sv
// Testbench: drives build, probe and clear transactions into the join table and checks responses.
`timescale 1ns / 1ps
module direct_index_join_table_tb;
    import dijt_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int REPORT_LIMIT    = 10;
    localparam int MAX_CLEARS      = 5;
    localparam int KEY_WINDOW      = 64;

    // Opcode 3 is unused by the block; width mode 3 keeps all four bytes
    localparam logic [OPCODE_W-1:0] OP_NOP          = 2'd3;
    localparam logic [MODE_W-1:0]   WM_WORD_ALT     = 2'd3;
    localparam logic [PADDR_W-1:0]  WIDTH_MODE_ADDR = PADDR_W'(4 * REG_WIDTH_MODE);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 hit;
        logic [PAYLOAD_W-1:0] hit_payload;
        logic [COUNT_W-1:0]   match_count;
    } join_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_MODE
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [OPCODE_W-1:0]  opcode;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [MODE_W-1:0]    mode;
        bit                   known;
        join_result_t         result;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    dijt_req_if req_ch ();
    dijt_rsp_if rsp_ch ();

    // Mirror of the table contents, counter and width register
    bit                   slot_present [TABLE_SLOTS];
    logic [PAYLOAD_W-1:0] slot_word [TABLE_SLOTS];
    logic [COUNT_W-1:0]   hit_total;
    logic [MODE_W-1:0]    width_mode;

    join_result_t         expected_results [$];
    stim_row_t            directed_rows [$];
    int                   mismatches;
    int                   clears_left;
    int                   cycles;

    direct_index_join_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Apply one transaction to the mirror and return the response it must produce
    function automatic join_result_t join_table_step(input logic [OPCODE_W-1:0] op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [PAYLOAD_W-1:0] payload);
        join_result_t      r;
        logic              in_range;
        logic [SLOT_W-1:0] slot;
        r        = '0;
        in_range = !key[KEY_W-1] && (key < KEY_W'(TABLE_SLOTS));
        slot     = key[SLOT_W-1:0];
        case (op)
            OP_BUILD:
            begin
                // Key sign, capacity and duplicate are tested before the payload sign
                if (key[KEY_W-1])
                    r.status = ST_NEG_KEY;
                else if (!in_range)
                    r.status = ST_KEY_RANGE;
                else if (slot_present[slot])
                    r.status = ST_DUPLICATE;
                else if (payload[PAYLOAD_W-1])
                    r.status = ST_NEG_PAYLOAD;
                else
                begin
                    case (width_mode)
                        WM_BYTE: slot_word[slot] = PAYLOAD_W'(payload[7:0]);
                        WM_HALF: slot_word[slot] = PAYLOAD_W'(payload[15:0]);
                        default: slot_word[slot] = payload;
                    endcase
                    slot_present[slot] = 1'b1;
                end
            end
            OP_PROBE:
            begin
                if (in_range && slot_present[slot])
                begin
                    r.hit         = 1'b1;
                    r.hit_payload = slot_word[slot];
                    if (hit_total != '1)
                        hit_total = hit_total + 1'b1;
                end
            end
            OP_CLEAR:
            begin
                foreach (slot_present[i])
                    slot_present[i] = 1'b0;
                hit_total = '0;
            end
            default:
            begin
            end
        endcase
        r.match_count = hit_total;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [OPCODE_W-1:0] op,
                                            input logic [KEY_W-1:0] key,
                                            input logic [PAYLOAD_W-1:0] payload,
                                            input logic [STATUS_W-1:0] status,
                                            input logic hit,
                                            input logic [PAYLOAD_W-1:0] hit_payload,
                                            input logic [COUNT_W-1:0] match_count);
        stim_row_t r;
        r.kind    = ROW_ITEM;
        r.opcode  = op;
        r.key     = key;
        r.payload = payload;
        r.mode    = WM_RESET;
        r.known   = 1'b1;
        r.result  = '{status, hit, hit_payload, match_count};
        return r;
    endfunction

    function automatic stim_row_t predicted_row(input logic [OPCODE_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [PAYLOAD_W-1:0] payload);
        stim_row_t r;
        r       = known_row(op, key, payload, ST_OK, 1'b0, '0, '0);
        r.known = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t mode_row(input logic [MODE_W-1:0] mode);
        stim_row_t r;
        r      = known_row(OP_NOP, '0, '0, ST_OK, 1'b0, '0, '0);
        r.kind = ROW_MODE;
        r.mode = mode;
        return r;
    endfunction

    // Offer one request after a random gap and queue its expected response on acceptance
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [PAYLOAD_W-1:0] payload, input bit calm,
                             input bit known, input join_result_t known_result);
        int           gap;
        join_result_t predicted;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid   = 1'b1;
        req_ch.opcode  = op;
        req_ch.key     = key;
        req_ch.payload = payload;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predicted = join_table_step(op, key, payload);
        expected_results.push_back(known ? known_result : predicted);
    endtask

    // Drop valid and hold until every queued response has come back
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of the width mode register: setup cycle, then access cycle
    task automatic write_width_mode(input logic [MODE_W-1:0] mode);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = WIDTH_MODE_ADDR;
        pwdata  = PDATA_W'(mode);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        width_mode = mode;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly builds and probes inside a small key window so hits and duplicates are common
    task automatic send_random_item(input logic [KEY_W-1:0] key_base, input bit calm);
        logic [OPCODE_W-1:0]  op;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        int                   pick;
        pick = $urandom_range(0, 99);
        if (clears_left > 0 && $urandom_range(0, ITEMS_PER_PHASE - 1) == 0)
        begin
            op = OP_CLEAR;
            clears_left--;
        end
        else if (pick < 47)
            op = OP_BUILD;
        else if (pick < 95)
            op = OP_PROBE;
        else
            op = OP_NOP;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            key = key_base + KEY_W'($urandom_range(0, KEY_WINDOW - 1));
        else if (pick < 72)
            key = KEY_W'($urandom_range(0, TABLE_SLOTS - 1));
        else if (pick < 82)
            key = KEY_W'(TABLE_SLOTS - 8 + $urandom_range(0, 15));
        else
            key = $urandom();
        if ($urandom_range(0, 4) == 0)
            payload = $urandom();
        else
            payload = $urandom() & 32'h7FFF_FFFF;
        send_item(op, key, payload, calm, 1'b0, '0);
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL direct_index_join_table");
        $finish;
    end

    // Response side: random back-pressure, compare each transaction with the oldest expectation
    initial
    begin : response_check
        int           stall;
        int           calm_left;
        join_result_t got;
        join_result_t want;
        rsp_ch.ready = 1'b0;
        calm_left    = 0;
        forever
        begin
            if (calm_left > 0)
            begin
                stall = 0;
                calm_left--;
            end
            else
            begin
                stall = $urandom_range(0, 5);
                if ($urandom_range(0, 31) == 0)
                    calm_left = $urandom_range(10, 60);
            end
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            got = '{rsp_ch.status, rsp_ch.hit, rsp_ch.hit_payload, rsp_ch.match_count};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response: status %0d hit %0d payload %h count %h",
                             got.status, got.hit, got.hit_payload, got.match_count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: exp status %0d hit %0d payload %h count %h, %s %0d %0d %h %h",
                                 want.status, want.hit, want.hit_payload, want.match_count,
                                 "got", got.status, got.hit, got.hit_payload, got.match_count);
                end
            end
        end
    end

    // Request side: reset, directed table, then random phases under each width mode
    initial
    begin : stimulus
        logic [MODE_W-1:0] phase_modes [PHASE_COUNT];
        logic [KEY_W-1:0]  key_base;
        bit                calm;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = OP_NOP;
        req_ch.key     = '0;
        req_ch.payload = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hit_total      = '0;
        width_mode     = WM_RESET;
        mismatches     = 0;
        clears_left    = MAX_CLEARS;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table, first hit, every refusal, table edges, unused opcode and clear
        directed_rows.push_back(known_row(OP_PROBE, 32'h0, 32'h0, ST_OK, 1'b0, 32'h0, 32'd0));
        directed_rows.push_back(known_row(OP_BUILD, 32'h0, 32'h7FFF_FFFF, ST_OK, 1'b0, 32'h0, 32'd0));
        directed_rows.push_back(known_row(OP_PROBE, 32'h0, 32'h0, ST_OK, 1'b1, 32'h7FFF_FFFF, 32'd1));
        directed_rows.push_back(known_row(OP_BUILD, 32'h0, 32'h5, ST_DUPLICATE, 1'b0, 32'h0, 32'd1));
        directed_rows.push_back(known_row(OP_BUILD, 32'hFFFF_FFFF, 32'h0, ST_NEG_KEY, 1'b0, 32'h0,
                                          32'd1));
        directed_rows.push_back(known_row(OP_BUILD, 32'h8000_0000, 32'hFFFF_FFFF, ST_NEG_KEY, 1'b0,
                                          32'h0, 32'd1));
        directed_rows.push_back(known_row(OP_BUILD, 32'h0001_0000, 32'h0, ST_KEY_RANGE, 1'b0, 32'h0,
                                          32'd1));
        directed_rows.push_back(known_row(OP_BUILD, 32'h7FFF_FFFF, 32'h8000_0000, ST_KEY_RANGE, 1'b0,
                                          32'h0, 32'd1));
        directed_rows.push_back(known_row(OP_BUILD, 32'h0000_FFFF, 32'h8000_0000, ST_NEG_PAYLOAD,
                                          1'b0, 32'h0, 32'd1));
        directed_rows.push_back(known_row(OP_BUILD, 32'h0000_FFFF, 32'h0, ST_OK, 1'b0, 32'h0, 32'd1));
        directed_rows.push_back(known_row(OP_PROBE, 32'h0000_FFFF, 32'h0, ST_OK, 1'b1, 32'h0, 32'd2));
        directed_rows.push_back(known_row(OP_PROBE, 32'h0001_0000, 32'h0, ST_OK, 1'b0, 32'h0, 32'd2));
        directed_rows.push_back(known_row(OP_PROBE, 32'hFFFF_FFFF, 32'h0, ST_OK, 1'b0, 32'h0, 32'd2));
        directed_rows.push_back(known_row(OP_PROBE, 32'h8000_0000, 32'h0, ST_OK, 1'b0, 32'h0, 32'd2));
        directed_rows.push_back(known_row(OP_NOP, 32'h1234, 32'h5678, ST_OK, 1'b0, 32'h0, 32'd2));
        directed_rows.push_back(known_row(OP_CLEAR, 32'h0, 32'h0, ST_OK, 1'b0, 32'h0, 32'd0));
        directed_rows.push_back(known_row(OP_PROBE, 32'h0, 32'h0, ST_OK, 1'b0, 32'h0, 32'd0));
        // Payload cut with the width in force at build time
        directed_rows.push_back(mode_row(WM_BYTE));
        directed_rows.push_back(predicted_row(OP_BUILD, 32'h1, 32'h7FFF_ABCD));
        directed_rows.push_back(mode_row(WM_HALF));
        directed_rows.push_back(predicted_row(OP_BUILD, 32'h2, 32'h7FFF_ABCD));
        directed_rows.push_back(mode_row(WM_WORD_ALT));
        directed_rows.push_back(predicted_row(OP_BUILD, 32'h3, 32'h7FFF_ABCD));
        directed_rows.push_back(predicted_row(OP_PROBE, 32'h1, 32'h0));
        directed_rows.push_back(predicted_row(OP_PROBE, 32'h2, 32'h0));
        directed_rows.push_back(predicted_row(OP_PROBE, 32'h3, 32'h0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_MODE)
            begin
                drain_results();
                write_width_mode(directed_rows[i].mode);
            end
            else
                send_item(directed_rows[i].opcode, directed_rows[i].key, directed_rows[i].payload,
                          $urandom_range(0, 3) == 0, directed_rows[i].known,
                          directed_rows[i].result);
        end

        // Random phases, each under its own width mode and key window
        phase_modes = '{WM_BYTE, WM_HALF, WM_RESET, WM_WORD_ALT, WM_BYTE, WM_RESET};
        foreach (phase_modes[p])
        begin
            drain_results();
            write_width_mode(phase_modes[p]);
            key_base = KEY_W'($urandom_range(0, TABLE_SLOTS - KEY_WINDOW));
            calm     = 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // Hold the sender until the block has answered everything
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_random_item(key_base, calm);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("PASS direct_index_join_table");
        else
            $display("FAIL direct_index_join_table");
        $finish;
    end

endmodule
